/* rtl/smou_pkg.sv */
package smou_pkg;

  localparam int WORD_W      = 64;
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = $clog2(WORD_W);

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

/* rtl/stack_machine_operand_unit.sv */
// Channel   Ports                                   Handshake
// command   start, cmd, immediate                   taken when start & !busy
// result    done, top_value, stack_depth, status    one-cycle strobe on done
//
// Push, pop and error cases pass through S_RDA, S_RDB and S_DECIDE to the done strobe.
// Arithmetic commands then wait in S_WAIT for the ALU; multiply and divide iterate
// through the shared 65-bit adder (shift-add or restoring division).
// busy stays high from acceptance until the done cycle, when a new
// command may be taken. Synchronous reset empties the stack.
// done cannot be held off and is high for that one cycle only; the outputs hold until the next command updates them.
module stack_machine_operand_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smou_pkg::CMD_W-1:0]    cmd,
  input  logic [smou_pkg::WORD_W-1:0]   immediate,
  output logic                          busy,
  output logic                          done,
  output logic [smou_pkg::WORD_W-1:0]   top_value,
  output logic [smou_pkg::SP_W-1:0]     stack_depth,
  output logic [smou_pkg::STATUS_W-1:0] status
);

  localparam int W = smou_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_DECIDE,
    S_WAIT
  } state_t;

  state_t                       state;
  logic [smou_pkg::SP_W-1:0]    sp;
  logic [smou_pkg::CMD_W-1:0]   cmd_r;
  logic [W-1:0]                 imm_r;
  logic [W-1:0]                 a_r;

  logic [smou_pkg::IDX_W-1:0]   sp_idx;
  logic [smou_pkg::IDX_W-1:0]   sp_m1;
  logic [smou_pkg::IDX_W-1:0]   sp_m2;
  logic                         is_full;
  logic                         has1;
  logic                         has2;
  logic                         is_arith;

  logic                         wr_en;
  logic [smou_pkg::IDX_W-1:0]   wr_addr;
  logic [W-1:0]                 wr_data;
  logic [smou_pkg::IDX_W-1:0]   rd_addr;
  logic [W-1:0]                 rd_data;

  smou_pkg::alu_req_t           alu_req;
  smou_pkg::alu_rsp_t           alu_rsp;

  assign sp_idx   = sp[smou_pkg::IDX_W-1:0];
  assign sp_m1    = sp_idx - 1'b1;
  assign sp_m2    = sp_idx - smou_pkg::IDX_W'(2);
  assign is_full  = sp >= smou_pkg::SP_W'(smou_pkg::STACK_DEPTH);
  assign has1     = sp != '0;
  assign has2     = sp >= smou_pkg::SP_W'(2);
  assign is_arith = (cmd_r == smou_pkg::CMD_ADD) || (cmd_r == smou_pkg::CMD_SUB) ||
                    (cmd_r == smou_pkg::CMD_MUL) || (cmd_r == smou_pkg::CMD_DIV);

  assign busy        = state != S_IDLE;
  assign stack_depth = sp;

  // rd_data holds the top entry in S_RDB and the next entry in S_DECIDE
  assign rd_addr = (state == S_RDA) ? sp_m1 : sp_m2;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sp_idx;
    wr_data = imm_r;
    if (state == S_DECIDE && cmd_r == smou_pkg::CMD_PUSH && !is_full) begin
      wr_en = 1'b1;
    end else if (state == S_WAIT && alu_rsp.done) begin
      wr_en   = 1'b1;
      wr_addr = sp_m2;
      wr_data = alu_rsp.result;
    end
  end

  always_comb begin
    case (cmd_r)
      smou_pkg::CMD_SUB: alu_req.op = smou_pkg::ALU_SUB;
      smou_pkg::CMD_MUL: alu_req.op = smou_pkg::ALU_MUL;
      smou_pkg::CMD_DIV: alu_req.op = smou_pkg::ALU_DIV;
      default:           alu_req.op = smou_pkg::ALU_ADD;
    endcase
    alu_req.go = (state == S_DECIDE) && is_arith && has2 &&
                 !(cmd_r == smou_pkg::CMD_DIV && rd_data == '0);
  end

  smou_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smou_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (a_r),
    .b   (rd_data),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            imm_r <= immediate;
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          a_r   <= rd_data;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          status    <= smou_pkg::ST_OK;
          top_value <= has1 ? a_r : '0;
          done      <= 1'b1;
          state     <= S_IDLE;
          case (cmd_r)
            smou_pkg::CMD_PUSH: begin
              if (is_full) begin
                status <= smou_pkg::ST_OVERFLOW;
              end else begin
                sp        <= sp + 1'b1;
                top_value <= imm_r;
              end
            end
            smou_pkg::CMD_POP: begin
              if (!has1) begin
                status <= smou_pkg::ST_UNDERFLOW;
              end else begin
                sp        <= sp - 1'b1;
                top_value <= has2 ? rd_data : '0;
              end
            end
            smou_pkg::CMD_ADD, smou_pkg::CMD_SUB, smou_pkg::CMD_MUL, smou_pkg::CMD_DIV: begin
              if (!has2) begin
                status <= smou_pkg::ST_UNDERFLOW;
              end else if (cmd_r == smou_pkg::CMD_DIV && rd_data == '0) begin
                status <= smou_pkg::ST_DIVZERO;
              end else begin
                done  <= 1'b0;
                state <= S_WAIT;
              end
            end
            default: status <= smou_pkg::ST_OK;
          endcase
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            sp        <= sp - 1'b1;
            top_value <= alu_rsp.result;
            status    <= smou_pkg::ST_OK;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/smou_stack.sv */
module smou_stack (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [smou_pkg::IDX_W-1:0] wr_addr,
  input  logic [smou_pkg::WORD_W-1:0] wr_data,
  input  logic [smou_pkg::IDX_W-1:0] rd_addr,
  output logic [smou_pkg::WORD_W-1:0] rd_data
);

  logic [smou_pkg::WORD_W-1:0] mem [smou_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/smou_alu.sv */
module smou_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  smou_pkg::alu_req_t          req,
  input  logic [smou_pkg::WORD_W-1:0] a,
  input  logic [smou_pkg::WORD_W-1:0] b,
  output smou_pkg::alu_rsp_t          rsp
);

  localparam int W = smou_pkg::WORD_W;

  typedef enum logic {
    A_IDLE,
    A_RUN
  } state_t;

  state_t                     state;
  smou_pkg::alu_op_t          op_r;
  logic [W-1:0]               acc;
  logic [W-1:0]               opd;
  logic [W-1:0]               shreg;
  logic [smou_pkg::CNT_W-1:0] cnt;

  // shared 65-bit add/subtract
  logic [W:0]   x;
  logic [W:0]   y;
  logic         sub;
  logic [W+1:0] sum;
  logic         cout;
  logic [W-1:0] s;

  always_comb begin
    x   = {1'b0, acc};
    y   = {1'b0, opd};
    sub = 1'b0;
    case (op_r)
      smou_pkg::ALU_SUB: sub = 1'b1;
      smou_pkg::ALU_DIV: begin
        x   = {acc, shreg[W-1]};
        sub = 1'b1;
      end
      default: sub = 1'b0;
    endcase
    sum  = {1'b0, x} + {1'b0, y ^ {(W + 1){sub}}} + (W + 2)'(sub);
    cout = sum[W+1];
    s    = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.go) begin
            op_r <= req.op;
            cnt  <= smou_pkg::CNT_W'(W - 1);
            case (req.op)
              smou_pkg::ALU_MUL: begin
                acc   <= '0;
                opd   <= a;
                shreg <= b;
              end
              smou_pkg::ALU_DIV: begin
                acc   <= '0;
                opd   <= b;
                shreg <= a;
              end
              default: begin
                acc   <= a;
                opd   <= b;
                shreg <= '0;
              end
            endcase
            state <= A_RUN;
          end
        end
        A_RUN: begin
          case (op_r)
            smou_pkg::ALU_MUL: begin
              if (shreg[0]) begin
                acc <= s;
              end
              opd   <= opd << 1;
              shreg <= shreg >> 1;
              cnt   <= cnt - 1'b1;
              if (cnt == '0) begin
                rsp.result <= shreg[0] ? s : acc;
                rsp.done   <= 1'b1;
                state      <= A_IDLE;
              end
            end
            smou_pkg::ALU_DIV: begin
              acc   <= cout ? s : x[W-1:0];
              shreg <= {shreg[W-2:0], cout};
              cnt   <= cnt - 1'b1;
              if (cnt == '0) begin
                rsp.result <= {shreg[W-2:0], cout};
                rsp.done   <= 1'b1;
                state      <= A_IDLE;
              end
            end
            default: begin
              rsp.result <= s;
              rsp.done   <= 1'b1;
              state      <= A_IDLE;
            end
          endcase
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule
